@@ hw/rtl/sps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Types and constants shared by the servo pulse sequencer and its channels.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned PIN_W   = 3;
  localparam int unsigned DUTY_N  = 3;
  localparam int unsigned RCNT_W  = 8;

  // item operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_WRITE = 2'd2,
    OP_RADIO = 2'd3
  } op_e;

  localparam logic [WIDTH_W-1:0] WAIT_LIMIT   = 16'd100;
  localparam logic [CHAN_W-1:0]  FIRST_SEQ_CH = 3'd4;
  localparam logic [RCNT_W-1:0]  RCNT_MAX     = 8'hFF;
  localparam logic [RCNT_W-1:0]  RCNT_ON      = 8'd2;

  typedef struct packed {
    logic signed [WIDTH_W-1:0] duty_one;
    logic signed [WIDTH_W-1:0] duty_two;
    logic signed [WIDTH_W-1:0] duty_three;
    logic [PIN_W-1:0]          pulse_pins;
    logic                      radio_on;
    logic                      sequencer_busy;
    logic [CHAN_W-1:0]         active_channel;
  } result_t;

endpackage

@@ hw/rtl/sps_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_in_if
// Input channel: operation, channel number and pulse width with valid/ready.
// ----------------------------------------------------------------------------
interface sps_in_if;

  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic [sps_pkg::CHAN_W-1:0]         channel;
  logic signed [sps_pkg::WIDTH_W-1:0] width;

  modport source (output valid, output op, output channel, output width, input ready);
  modport sink   (input valid, input op, input channel, input width, output ready);

endinterface

@@ hw/rtl/sps_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_out_if
// Result channel: latched duties, pin levels and sequencer status.
// ----------------------------------------------------------------------------
interface sps_out_if;

  logic                               valid;
  logic                               ready;
  logic signed [sps_pkg::WIDTH_W-1:0] duty_one;
  logic signed [sps_pkg::WIDTH_W-1:0] duty_two;
  logic signed [sps_pkg::WIDTH_W-1:0] duty_three;
  logic [sps_pkg::PIN_W-1:0]          pulse_pins;
  logic                               radio_on;
  logic                               sequencer_busy;
  logic [sps_pkg::CHAN_W-1:0]         active_channel;

  modport source (
    output valid, output duty_one, output duty_two, output duty_three,
    output pulse_pins, output radio_on, output sequencer_busy,
    output active_channel, input ready
  );
  modport sink (
    input valid, input duty_one, input duty_two, input duty_three,
    input pulse_pins, input radio_on, input sequencer_busy,
    input active_channel, output ready
  );

endinterface

@@ hw/rtl/servo_pulse_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pulse_sequencer: one result per item via input and result registers;
// throughput one item per cycle while results are taken, set by the single
// update pass between the two; reset clears stored widths, duties and timer
// ----------------------------------------------------------------------------
module servo_pulse_sequencer #(
  parameter int unsigned CHANNEL_COUNT = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  sps_in_if.sink           in_i,
  sps_out_if.source        out_o
);

  localparam int unsigned IDX_W = $clog2(CHANNEL_COUNT);
  localparam logic [sps_pkg::CHAN_W-1:0] LAST_CH = sps_pkg::CHAN_W'(CHANNEL_COUNT);

  // input register
  logic                                a_valid_q;
  sps_pkg::op_e                        a_op_q;
  logic [sps_pkg::CHAN_W-1:0]          a_ch_q;
  logic [sps_pkg::WIDTH_W-1:0]         a_w_q;

  // result register
  logic                                r_valid_q;
  sps_pkg::result_t                    res_q, res_d;

  // block state
  logic                                no_radio_q;
  logic [sps_pkg::WIDTH_W-1:0]         store_q [CHANNEL_COUNT];
  logic [sps_pkg::WIDTH_W-1:0]         duty_q [sps_pkg::DUTY_N];
  logic [sps_pkg::WIDTH_W-1:0]         duty_d [sps_pkg::DUTY_N];
  logic                                parity_q, parity_d;
  logic [sps_pkg::RCNT_W-1:0]          rcnt_q, rcnt_d;
  logic                                flag_q, flag_d;
  logic [sps_pkg::CHAN_W-1:0]          cur_q, cur_d;
  logic [sps_pkg::WIDTH_W-1:0]         tcnt_q, tcnt_d;
  logic [sps_pkg::WIDTH_W-1:0]         tlim_q, tlim_d;
  logic [sps_pkg::PIN_W-1:0]           pins_q, pins_d;
  logic                                run_q, run_d;

  logic                                adv;
  logic                                store_we;
  logic [IDX_W-1:0]                    store_idx;
  logic                                start_req;
  logic [sps_pkg::CHAN_W-1:0]          start_ch;
  logic [sps_pkg::WIDTH_W-1:0]         start_w;
  logic [1:0]                          start_off;
  logic [1:0]                          end_off;
  logic [sps_pkg::PIN_W-1:0]           start_mask;
  logic [sps_pkg::PIN_W-1:0]           end_mask;

  // the item in the input register moves on whenever the result slot frees
  assign adv        = a_valid_q && (!r_valid_q || out_o.ready);
  assign in_i.ready = !a_valid_q || adv;

  assign store_we  = (a_op_q == sps_pkg::OP_WRITE) && (a_ch_q != '0) && (a_ch_q <= LAST_CH);
  assign store_idx = IDX_W'(a_ch_q - 3'd1);

  always_comb begin
    duty_d    = duty_q;
    parity_d  = parity_q;
    rcnt_d    = rcnt_q;
    flag_d    = flag_q;
    cur_d     = cur_q;
    tcnt_d    = tcnt_q;
    tlim_d    = tlim_q;
    pins_d    = pins_q;
    run_d     = run_q;
    start_req = 1'b0;
    start_ch  = sps_pkg::FIRST_SEQ_CH;
    end_off   = 2'(cur_q - sps_pkg::FIRST_SEQ_CH);
    end_mask  = 3'b001 << end_off;

    case (a_op_q)
      sps_pkg::OP_TICK: begin
        if (run_q) begin
          if (tcnt_q == tlim_q) begin
            if (cur_q >= sps_pkg::FIRST_SEQ_CH && cur_q <= 3'd6) begin
              pins_d = pins_q & ~end_mask;
            end
            if (cur_q >= sps_pkg::FIRST_SEQ_CH && cur_q < LAST_CH) begin
              start_req = 1'b1;
              start_ch  = cur_q + 3'd1;
            end else begin
              run_d = 1'b0;
            end
          end else begin
            tcnt_d = tcnt_q + 16'd1;
          end
        end
      end
      sps_pkg::OP_FRAME: begin
        if (!no_radio_q) begin
          parity_d = ~parity_q;
          // radio judged on every second frame
          if (!parity_d) begin
            if (rcnt_q == '0) begin
              flag_d = 1'b0;
            end else if (rcnt_q >= sps_pkg::RCNT_ON) begin
              flag_d = 1'b1;
            end
            rcnt_d = '0;
          end
        end
        for (int i = 0; i < sps_pkg::DUTY_N; i++) begin
          duty_d[i] = store_q[i];
        end
        if (CHANNEL_COUNT > 3) begin
          pins_d    = '0;
          start_req = 1'b1;
        end
      end
      sps_pkg::OP_WRITE: begin
      end
      sps_pkg::OP_RADIO: begin
        if (rcnt_q != sps_pkg::RCNT_MAX) begin
          rcnt_d = rcnt_q + 8'd1;
        end
      end
      default: begin
      end
    endcase

    // channel start shared by frame and end of previous channel
    start_w    = store_q[IDX_W'(start_ch - 3'd1)];
    start_off  = 2'(start_ch - sps_pkg::FIRST_SEQ_CH);
    start_mask = 3'b001 << start_off;
    if (start_req) begin
      cur_d  = start_ch;
      tcnt_d = '0;
      run_d  = 1'b1;
      if (start_w != '0 && !start_w[sps_pkg::WIDTH_W-1]) begin
        tlim_d = {start_w[sps_pkg::WIDTH_W-2:0], 1'b0};
        pins_d = pins_d | start_mask;
      end else begin
        tlim_d = sps_pkg::WAIT_LIMIT;
        pins_d = pins_d & ~start_mask;
      end
    end

    res_d.duty_one       = signed'(duty_d[0]);
    res_d.duty_two       = signed'(duty_d[1]);
    res_d.duty_three     = signed'(duty_d[2]);
    res_d.pulse_pins     = pins_d;
    res_d.radio_on       = flag_d | no_radio_q;
    res_d.sequencer_busy = run_d;
    res_d.active_channel = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_radio_q <= 1'b0;
    end else if (cfg_we_i) begin
      no_radio_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_op_q <= sps_pkg::op_e'(in_i.op);
      a_ch_q <= in_i.channel;
      a_w_q  <= in_i.width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (adv) begin
      r_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        store_q[i] <= '0;
      end
      for (int i = 0; i < sps_pkg::DUTY_N; i++) begin
        duty_q[i] <= '0;
      end
      parity_q <= 1'b0;
      rcnt_q   <= '0;
      flag_q   <= 1'b0;
      cur_q    <= '0;
      tcnt_q   <= '0;
      tlim_q   <= '0;
      pins_q   <= '0;
      run_q    <= 1'b0;
    end else if (adv) begin
      if (store_we) begin
        store_q[store_idx] <= a_w_q;
      end
      duty_q   <= duty_d;
      parity_q <= parity_d;
      rcnt_q   <= rcnt_d;
      flag_q   <= flag_d;
      cur_q    <= cur_d;
      tcnt_q   <= tcnt_d;
      tlim_q   <= tlim_d;
      pins_q   <= pins_d;
      run_q    <= run_d;
    end
  end

  assign out_o.valid          = r_valid_q;
  assign out_o.duty_one       = res_q.duty_one;
  assign out_o.duty_two       = res_q.duty_two;
  assign out_o.duty_three     = res_q.duty_three;
  assign out_o.pulse_pins     = res_q.pulse_pins;
  assign out_o.radio_on       = res_q.radio_on;
  assign out_o.sequencer_busy = res_q.sequencer_busy;
  assign out_o.active_channel = res_q.active_channel;

  // a running timer always times a sequenced channel
  a_run_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (cur_q >= sps_pkg::FIRST_SEQ_CH && cur_q <= LAST_CH))
    else $error("timer running on a channel outside the sequence");

  // at most one pin high, and only while the timer runs
  a_pins_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pins_q) && (pins_q == '0 || run_q))
    else $error("pin levels inconsistent with sequencer");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> tcnt_q <= tlim_q)
    else $error("tick count passed its limit");

  // a buffered item survives a stalled result
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && r_valid_q && !out_o.ready) |=> (a_valid_q && r_valid_q))
    else $error("item or result dropped during stall");

endmodule
